// ----- src/pbfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbfe_pkg: shared types and constants
// Command and status structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package pbfe_pkg;

  localparam int unsigned QW    = 32;  // Q16.16 result width
  localparam int unsigned VOLW  = 40;  // volume width
  localparam int unsigned NUMW  = 41;  // signed difference magnitude width
  localparam int unsigned DIVW  = NUMW + 16;  // shifted dividend width
  localparam int unsigned SQW   = 80;  // radicand width
  localparam int unsigned RTW   = 40;  // root width

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_DIV_STORE,
    ST_SUMSQ,
    ST_ROOT,
    ST_VDIV,
    ST_COMMIT,
    ST_OUT
  } state_e;

  // Which ratio the shared divider computes.
  typedef enum logic [2:0] {
    R_RET,
    R_OC,
    R_RC,
    R_CIR,
    R_VC,
    R_MOM
  } ratio_e;

  typedef struct packed {
    logic   load;       // latch the input bar
    logic   div_start;  // load divider with selected ratio
    logic   div_step;   // one quotient bit
    logic   div_store;  // saturate and store quotient
    ratio_e sel;
    logic   sumsq_step; // accumulate one pair
    logic   root_start;
    logic   root_step;
    logic   vdiv_step;  // root divided by count, one bit
    logic   commit;     // update history
    logic   out_load;   // load output register
  } pbfe_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sumsq_done;
    logic root_done;
    logic vdiv_done;
  } pbfe_sts_t;

endpackage

// ----- src/pbfe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbfe_ctrl: sequencing controller
// Steps the datapath through six ratios, the variance sum, the root and
// the final division, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module pbfe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pbfe_pkg::pbfe_sts_t sts_i,
  output pbfe_pkg::pbfe_cmd_t cmd_o
);
  import pbfe_pkg::*;

  state_e state_q, state_d;
  ratio_e sel_q, sel_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= R_RET;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    cmd_o.sel = sel_q;
    in_ready_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        sel_d = R_RET;
        state_d = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_DIV_STORE;
      end
      ST_DIV_STORE: begin
        cmd_o.div_store = 1'b1;
        if (sel_q == R_MOM) begin
          state_d = ST_SUMSQ;
        end else begin
          sel_d = ratio_e'(sel_q + 3'd1);
          state_d = ST_DIV_START;
        end
      end
      ST_SUMSQ: begin
        cmd_o.sumsq_step = 1'b1;
        if (sts_i.sumsq_done) begin
          cmd_o.root_start = 1'b1;
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_done) state_d = ST_VDIV;
      end
      ST_VDIV: begin
        cmd_o.vdiv_step = 1'b1;
        if (sts_i.vdiv_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ov_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_load_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!ov_q || out_ready_i)) else $error("result overwritten");
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_LOAD) else $error("bad accept");
`endif

endmodule

// ----- src/pbfe_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbfe_dp: feature datapath
// History registers, one shared restoring divider, the pairwise variance
// accumulator, a digit-by-digit square root, a divide by the window count and the output register.
// ----------------------------------------------------------------------------
module pbfe_dp #(
  parameter int unsigned MomLookback = 3,
  parameter int unsigned VolWindow   = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbfe_pkg::pbfe_cmd_t cmd_i,
  output pbfe_pkg::pbfe_sts_t sts_o,
  input  logic                series_start_i,
  input  logic [31:0]         open_i,
  input  logic [31:0]         high_i,
  input  logic [31:0]         low_i,
  input  logic [31:0]         close_i,
  input  logic [39:0]         volume_i,
  output logic [223:0]        res_o
);
  import pbfe_pkg::*;

  localparam int unsigned DaysMax = (MomLookback > VolWindow) ? MomLookback : VolWindow;
  localparam int unsigned DW = $clog2(DaysMax + 1);
  localparam int unsigned VW = $clog2(VolWindow + 1);
  localparam int unsigned PW = (VolWindow > 1) ? $clog2(VolWindow) : 1;

  // History.
  logic [DW-1:0]   days_q;
  logic [31:0]     closes_q [MomLookback];
  logic [VOLW-1:0] pvol_q;
  logic [31:0]     rets_q [VolWindow];  // slot 0 is this bar's return

  // Latched bar.
  logic [31:0] op_q, hi_q, lo_q, cl_q;
  logic [VOLW-1:0] vol_q;
  logic [DW-1:0] d_q;

  // Features.
  logic [31:0] feat_q [6];
  logic [30:0] vola_q;

  // Divider.
  logic [DIVW-1:0] dvd_q;   // remaining dividend bits
  logic [NUMW-1:0] dvs_q;
  logic [NUMW:0]   rem_q;
  logic [DIVW-1:0] quo_q;
  logic            neg_q, zero_q;
  logic [5:0]      dcnt_q;

  // Operand selection for the divider.
  logic signed [NUMW:0] num_s, den_s;
  logic [NUMW-1:0] num_m, den_m;
  always_comb begin
    num_s = '0;
    den_s = '0;
    case (cmd_i.sel)
      R_RET: if (d_q != '0) begin
        num_s = $signed({10'd0, cl_q}) - $signed({10'd0, closes_q[0]});
        den_s = $signed({10'd0, closes_q[0]});
      end
      R_OC: begin
        num_s = $signed({10'd0, cl_q}) - $signed({10'd0, op_q});
        den_s = $signed({10'd0, op_q});
      end
      R_RC: begin
        num_s = $signed({10'd0, hi_q}) - $signed({10'd0, lo_q});
        den_s = $signed({10'd0, cl_q});
      end
      R_CIR: begin
        num_s = $signed({10'd0, cl_q}) - $signed({10'd0, lo_q});
        den_s = $signed({10'd0, hi_q}) - $signed({10'd0, lo_q});
      end
      R_VC: begin
        if (d_q != '0) begin
          num_s = $signed({2'd0, vol_q}) - $signed({2'd0, pvol_q});
          den_s = $signed({2'd0, pvol_q});
        end else begin
          num_s = $signed({2'd0, vol_q});
        end
      end
      R_MOM: if (d_q >= DW'(MomLookback)) begin
        num_s = $signed({10'd0, cl_q}) - $signed({10'd0, closes_q[MomLookback-1]});
        den_s = $signed({10'd0, closes_q[MomLookback-1]});
      end
      default: ;
    endcase
    num_m = num_s[NUMW] ? NUMW'(-num_s) : num_s[NUMW-1:0];
    den_m = den_s[NUMW] ? NUMW'(-den_s) : den_s[NUMW-1:0];
  end

  logic [NUMW:0] rem_sh, rem_sub;
  assign rem_sh  = {rem_q[NUMW-1:0], dvd_q[DIVW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  logic [31:0] quo_sat;
  always_comb begin
    if (zero_q) quo_sat = '0;
    else if (neg_q) quo_sat = (quo_q >= DIVW'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-quo_q);
    else quo_sat = (quo_q > DIVW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_q[31:0];
  end

  // Variance accumulation over pairs (i, j), i < j < n.
  logic [VW-1:0] n_q;
  logic [PW-1:0] pi_q, pj_q;
  logic [SQW-1:0] acc_q;
  logic          sq_done_q;
  logic signed [32:0] pd;
  logic [32:0] pm;
  assign pd = $signed({rets_q[pi_q][31], rets_q[pi_q]}) - $signed({rets_q[pj_q][31], rets_q[pj_q]});
  assign pm = pd[32] ? 33'(-pd) : pd;
  logic [65:0] psq;
  assign psq = pm * pm;

  // Root: two radicand bits per step are shifted out of the accumulator
  // into the partial remainder; a trial of 4 * root + 1 decides each bit.
  logic [RTW-1:0] root_q;
  logic [RTW+1:0] rrem_q;
  logic [5:0]     rcnt_q;
  logic [RTW+1:0] rsh, rtrial, rsub;
  assign rsh    = {rrem_q[RTW-1:0], acc_q[SQW-1 -: 2]};
  assign rtrial = {root_q, 2'b01};
  assign rsub   = rsh - rtrial;

  // Final division of the root by the window count.
  logic [RTW-1:0] vq_q;
  logic [VW:0]    vrem_q;
  logic [5:0]     vcnt_q;
  logic [VW:0]    vsh;
  assign vsh = {vrem_q[VW-1:0], root_q[vcnt_q - 6'd1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      days_q <= '0;
      pvol_q <= '0;
      for (int i = 0; i < MomLookback; i++) closes_q[i] <= '0;
      for (int i = 0; i < VolWindow; i++) rets_q[i] <= '0;
      dcnt_q <= '0;
      rcnt_q <= '0;
      vcnt_q <= '0;
      sq_done_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        op_q <= open_i; hi_q <= high_i; lo_q <= low_i; cl_q <= close_i;
        vol_q <= volume_i;
        d_q <= series_start_i ? '0 : days_q;
        if (series_start_i) begin
          days_q <= '0;
          pvol_q <= '0;
          for (int i = 0; i < MomLookback; i++) closes_q[i] <= '0;
          for (int i = 1; i < VolWindow; i++) rets_q[i - 1] <= '0;
          rets_q[VolWindow-1] <= '0;
        end
      end
      if (cmd_i.div_start) begin
        dvd_q  <= {num_m, 16'd0};
        dvs_q  <= den_m;
        rem_q  <= '0;
        quo_q  <= '0;
        neg_q  <= num_s[NUMW] ^ den_s[NUMW];
        zero_q <= (den_m == '0);
        dcnt_q <= 6'(DIVW);
      end
      if (cmd_i.div_step && dcnt_q != '0) begin
        dcnt_q <= dcnt_q - 6'd1;
        dvd_q  <= dvd_q << 1;
        if (!rem_sub[NUMW]) begin
          rem_q <= rem_sub;
          quo_q <= {quo_q[DIVW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[DIVW-2:0], 1'b0};
        end
      end
      if (cmd_i.div_store) begin
        feat_q[cmd_i.sel] <= quo_sat;
        if (cmd_i.sel == R_RET) begin
          for (int i = VolWindow - 1; i > 0; i--) rets_q[i] <= rets_q[i - 1];
          rets_q[0] <= quo_sat;
        end
        if (cmd_i.sel == R_MOM) begin
          n_q  <= (d_q < DW'(VolWindow)) ? VW'(d_q) : VW'(VolWindow);
          pi_q <= '0;
          pj_q <= PW'(1);
          acc_q <= '0;
          sq_done_q <= 1'b0;
        end
      end
      if (cmd_i.sumsq_step && !sq_done_q) begin
        if (VW'(pj_q) < n_q && VolWindow > 1) begin
          acc_q <= acc_q + SQW'(psq);
        end
        if (VW'(pj_q) + 1'b1 < n_q && VolWindow > 1) begin
          pj_q <= pj_q + 1'b1;
        end else if (VW'(pi_q) + 2'd2 < n_q && VolWindow > 1) begin
          pi_q <= pi_q + 1'b1;
          pj_q <= pi_q + 2'd2;
        end else begin
          sq_done_q <= 1'b1;
        end
      end
      if (cmd_i.root_start) begin
        root_q <= '0;
        rrem_q <= '0;
        rcnt_q <= 6'(RTW - 1);
      end
      if (cmd_i.root_step) begin
        acc_q <= acc_q << 2;
        if (rsh >= rtrial) begin
          rrem_q <= rsub;
          root_q <= {root_q[RTW-2:0], 1'b1};
        end else begin
          rrem_q <= rsh;
          root_q <= {root_q[RTW-2:0], 1'b0};
        end
        if (rcnt_q != '0) rcnt_q <= rcnt_q - 6'd1;
        else begin
          vcnt_q <= 6'(RTW);
          vrem_q <= '0;
          vq_q   <= '0;
        end
      end
      if (cmd_i.vdiv_step && vcnt_q != '0) begin
        vcnt_q <= vcnt_q - 6'd1;
        if (vsh >= {1'b0, n_q}) begin
          vrem_q <= vsh - {1'b0, n_q};
          vq_q <= {vq_q[RTW-2:0], 1'b1};
        end else begin
          vrem_q <= vsh;
          vq_q <= {vq_q[RTW-2:0], 1'b0};
        end
      end
      if (cmd_i.commit) begin
        for (int i = MomLookback - 1; i > 0; i--) closes_q[i] <= closes_q[i - 1];
        closes_q[0] <= cl_q;
        pvol_q <= vol_q;
        if (d_q < DW'(DaysMax)) days_q <= d_q + 1'b1;
        else days_q <= d_q;
        if (n_q == '0) vola_q <= '0;
        else vola_q <= (vq_q > RTW'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF : vq_q[30:0];
      end
      if (cmd_i.out_load) begin
        res_o <= {1'b0, vola_q, feat_q[R_MOM], feat_q[R_VC], feat_q[R_CIR],
                  feat_q[R_RC], feat_q[R_OC], feat_q[R_RET]};
      end
    end
  end

  // The root unit leaves vcnt at zero until its last step; guard the
  // final divide so it only reports done after it has run.
  logic vd_run_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_run_q <= 1'b0;
    else if (cmd_i.root_step && rcnt_q == '0) vd_run_q <= 1'b1;
    else if (cmd_i.vdiv_step && vcnt_q == '0) vd_run_q <= 1'b0;
  end

  assign sts_o.div_done   = (dcnt_q == 6'd1);
  assign sts_o.sumsq_done = sq_done_q;
  assign sts_o.root_done  = cmd_i.root_step && (rcnt_q == '0);
  assign sts_o.vdiv_done  = vd_run_q && (vcnt_q == '0);

`ifndef SYNTH
  a_days_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    days_q <= DW'(DaysMax)) else $error("day count overflow");
  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_store && zero_q) |=> feat_q[$past(cmd_i.sel)] == '0)
    else $error("zero divisor gave nonzero");
  a_root_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.vdiv_step |-> rrem_q <= {1'b0, root_q, 1'b0}) else $error("root too small");
`endif

endmodule

// ----- src/price_bar_feature_extractor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_bar_feature_extractor: daily bar feature engine
// Derives seven Q16.16 features from each price bar using one shared
// divider and a serial square root.
// ----------------------------------------------------------------------------
//  Port group | Direction | Contents
//  s_axis_*   | in        | one bar: flag, open, high, low, close, volume
//  m_axis_*   | out       | seven features for that bar
//
// Each accepted bar runs through the idle and load states, six shared-divider
// passes (setup, 57 quotient steps, store), the variance accumulation, 40
// square-root steps, the division of the root by the window count, one
// commit and one output load; the next bar is taken only in the idle state
// after that. Reset clears all history; the first bar after reset starts a
// series. The result waits in the output register while the next bar is
// taken; a result still waiting when the next one is done stalls it in the
// last state.
module price_bar_feature_extractor #(
  parameter int unsigned MOMENTUM_LOOKBACK = 3,
  parameter int unsigned VOL_WINDOW        = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: open_price, high_price, low_price, close_price, volume
  input  logic [167:0] s_axis_tdata,
  // tuser: series_start
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: close_return, open_close_return, range_over_close,
  // close_in_range, volume_change, momentum, volatility, one zero pad bit
  output logic [223:0] m_axis_tdata
);
  import pbfe_pkg::*;

  pbfe_cmd_t cmd;
  pbfe_sts_t sts;

  pbfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pbfe_dp #(
    .MomLookback (MOMENTUM_LOOKBACK),
    .VolWindow   (VOL_WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .series_start_i (s_axis_tuser),
    .open_i         (s_axis_tdata[31:0]),
    .high_i         (s_axis_tdata[63:32]),
    .low_i          (s_axis_tdata[95:64]),
    .close_i        (s_axis_tdata[127:96]),
    .volume_i       (s_axis_tdata[167:128]),
    .res_o          (m_axis_tdata)
  );

endmodule

// ----- test/price_bar_feature_extractor_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_bar_feature_extractor_tb: self-checking bench for the bar engine
// Drives daily price bars on the input stream and compares every set of
// seven features against a behavioral predictor kept inside the bench.
// ----------------------------------------------------------------------------
module price_bar_feature_extractor_tb;

  localparam int unsigned LOOKBACK = 3;
  localparam int unsigned WINDOW   = 3;
  localparam int unsigned N_RANDOM = 1200;
  localparam longint      Q_MAX    = 64'sd2147483647;
  localparam longint      Q_MIN    = -64'sd2147483648;

  typedef struct packed {
    logic [39:0] volume;
    logic [31:0] close_price;
    logic [31:0] low_price;
    logic [31:0] high_price;
    logic [31:0] open_price;
  } bar_t;

  typedef struct packed {
    logic        pad;
    logic [30:0] volatility;
    logic [31:0] momentum;
    logic [31:0] volume_change;
    logic [31:0] close_in_range;
    logic [31:0] range_over_close;
    logic [31:0] open_close_return;
    logic [31:0] close_return;
  } features_t;

  typedef struct {
    logic      start;
    bar_t      bar;
    logic      known;     // expected features typed in below
    features_t feat;
  } row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [223:0] m_axis_tdata;

  price_bar_feature_extractor #(
    .MOMENTUM_LOOKBACK(LOOKBACK),
    .VOL_WINDOW(WINDOW)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Predictor state for the current series.
  int unsigned hist_days;
  logic [31:0] hist_close[LOOKBACK];
  logic [39:0] hist_volume;
  longint      hist_ret[WINDOW];

  features_t pending_features[$];
  int        errors;
  bit        quiet;        // disables random idling for a stretch

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #600ms;
    $display("price_bar_feature_extractor_tb: errors");
    $finish;
  end

  // Quotient num * 2^16 / den, truncated toward zero, saturated.
  function automatic longint q16_ratio(longint num, longint den);
    logic [127:0] un, ud, q;
    bit           neg;
    if (den == 0) return 0;
    neg = (num < 0) != (den < 0);
    un  = num < 0 ? -num : num;
    ud  = den < 0 ? -den : den;
    q   = (un << 16) / ud;
    if (neg) return q >= 128'd2147483648 ? Q_MIN : -longint'(q);
    return q > Q_MAX ? Q_MAX : longint'(q);
  endfunction

  function automatic logic [63:0] isqrt128(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  c;
    r = 0;
    for (int b = 39; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= v) r = c;
    end
    return r;
  endfunction

  // Advances the series history by one bar and returns its features.
  function automatic features_t bar_features(logic start, bar_t b);
    longint       cl, ret, prev_vol, d;
    int unsigned  n;
    logic [127:0] sumsq;
    logic [63:0]  sd;
    features_t    f;
    if (start) begin
      hist_days = 0;
      hist_volume = 0;
      foreach (hist_close[i]) hist_close[i] = 0;
      foreach (hist_ret[i]) hist_ret[i] = 0;
    end
    cl  = b.close_price;
    ret = hist_days > 0 ? q16_ratio(cl - hist_close[0], hist_close[0]) : 0;
    f   = '0;
    f.close_return      = ret[31:0];
    f.open_close_return = 32'(q16_ratio(cl - b.open_price, b.open_price));
    f.range_over_close  =
      32'(q16_ratio(longint'(b.high_price) - b.low_price, cl));
    f.close_in_range    = 32'(q16_ratio(cl - b.low_price,
                                        longint'(b.high_price) - b.low_price));
    prev_vol = hist_days > 0 ? hist_volume : 0;
    f.volume_change     = 32'(q16_ratio(longint'(b.volume) - prev_vol, prev_vol));
    if (hist_days >= LOOKBACK)
      f.momentum = 32'(q16_ratio(cl - hist_close[LOOKBACK-1], hist_close[LOOKBACK-1]));
    for (int i = WINDOW - 1; i > 0; i--) hist_ret[i] = hist_ret[i-1];
    hist_ret[0] = ret;
    n = hist_days < WINDOW ? hist_days : WINDOW;
    sumsq = 0;
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++) begin
        d = hist_ret[i] - hist_ret[j];
        if (d < 0) d = -d;
        sumsq += 128'(d) * 128'(d);
      end
    sd = n == 0 ? 0 : isqrt128(sumsq) / n;
    f.volatility = sd > Q_MAX ? 31'h7fffffff : sd[30:0];
    for (int i = LOOKBACK - 1; i > 0; i--) hist_close[i] = hist_close[i-1];
    hist_close[0] = b.close_price;
    hist_volume   = b.volume;
    if (hist_days < (LOOKBACK > WINDOW ? LOOKBACK : WINDOW)) hist_days++;
    return f;
  endfunction

  // Prices drawn mostly near a moving level, sometimes at the edges.
  function automatic logic [31:0] rand_price(logic [31:0] level);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 3) == 0 ? 32'd0 : 32'hffffffff;
      default: return level + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  task automatic send_bar(logic start, bar_t b);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= start;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_features.insert(pending_features.size(), bar_features(start, b));
    if (!quiet && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Output side: random back-pressure and the feature comparison.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        features_t got, want;
        got = m_axis_tdata;
        if (pending_features.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = pending_features.pop_front();
          if (got !== want) begin
            $display("%0t: feature mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
      m_axis_tready <= quiet || $urandom_range(0, 99) >= 10;
    end
  end

  initial begin
    row_t        rows[$];
    row_t        r;
    bar_t        b;
    logic [31:0] level;
    int unsigned wait_cycles;

    errors        = 0;
    quiet         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    hist_days     = 0;
    hist_volume   = 0;
    foreach (hist_close[i]) hist_close[i] = 0;
    foreach (hist_ret[i]) hist_ret[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First bar after reset without the flag, all zero: every feature zero.
    r = '{1'b0, '0, 1'b1, '0};
    rows.insert(rows.size(), r);
    // All prices at maximum, open equal close: ratios zero or exact.
    r = '{1'b1, '{40'hff_ffff_ffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                  32'hffffffff}, 1'b1, '0};
    rows.insert(rows.size(), r);
    // Zero open: open-to-close return is zero by the division rule.
    r = '{1'b1, '{40'd100, 32'h0001_0000, 32'h0000_0000, 32'h0002_0000, 32'd0},
          1'b0, '0};
    rows.insert(rows.size(), r);
    // A maximum close against a unit open saturates positive.
    r = '{1'b0, '{40'd0, 32'hffffffff, 32'd0, 32'hffffffff, 32'd1}, 1'b0, '0};
    rows.insert(rows.size(), r);
    // Close at zero: range over close zero, returns to minus one.
    r = '{1'b0, '{40'hff_ffff_ffff, 32'd0, 32'd0, 32'd0, 32'h0001_0000}, 1'b0, '0};
    rows.insert(rows.size(), r);
    // Inverted range (high below low), then recovering closes for momentum.
    r = '{1'b0, '{40'd5, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000,
                  32'h0002_0000}, 1'b0, '0};
    rows.insert(rows.size(), r);
    r = '{1'b0, '{40'd7, 32'h0005_0000, 32'h0002_0000, 32'h0006_0000,
                  32'h0004_0000}, 1'b0, '0};
    rows.insert(rows.size(), r);
    r = '{1'b0, '{40'd1, 32'h0001_8000, 32'h0001_0000, 32'h0002_0000,
                  32'h0001_8000}, 1'b0, '0};
    rows.insert(rows.size(), r);
    r = '{1'b0, '{40'd9, 32'h8000_0000, 32'h0000_0001, 32'hffff_0000,
                  32'h0000_0001}, 1'b0, '0};
    rows.insert(rows.size(), r);
    r = '{1'b0, '{40'd3, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                  32'hffff_ffff}, 1'b0, '0};
    rows.insert(rows.size(), r);

    foreach (rows[i]) begin
      send_bar(rows[i].start, rows[i].bar);
      if (rows[i].known && pending_features[$] !== rows[i].feat) begin
        $display("%0t: predictor disagrees on row %0d expected %h actual %h",
                 $time, i, rows[i].feat, pending_features[$]);
        errors++;
      end
    end

    // Random series of varying length; a quiet stretch in the middle.
    level = 32'h0064_0000;
    for (int k = 0; k < N_RANDOM; k++) begin
      quiet = k >= 400 && k < 550;
      if ($urandom_range(0, 19) == 0) level = $urandom;
      b.open_price  = rand_price(level);
      b.high_price  = rand_price(level);
      b.low_price   = rand_price(level);
      b.close_price = rand_price(level);
      b.volume      = $urandom_range(0, 7) == 0 ? 40'({$urandom, $urandom}) :
                      40'($urandom_range(0, 1000000));
      level = b.close_price;
      send_bar($urandom_range(0, 15) == 0, b);
    end
    s_axis_tvalid <= 1'b0;

    wait_cycles = 0;
    while (pending_features.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (1000) @(posedge clk_i);
    if (errors == 0 && pending_features.size() == 0) begin
      $display("price_bar_feature_extractor_tb: clean");
    end else begin
      $display("price_bar_feature_extractor_tb: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pbfe_pkg.sv
src/pbfe_ctrl.sv
src/pbfe_dp.sv
src/price_bar_feature_extractor.sv
test/price_bar_feature_extractor_tb.sv
